// File: rtl/core/mcst_pkg.sv
package mcst_pkg;

  // Number of timer channels and the widths that follow from it.
  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  // The channel field is four bits wide, so at most sixteen channels are scanned.
  localparam int SCAN_N      = (TIMER_SLOTS < 16) ? TIMER_SLOTS : 16;
  localparam logic [8:0] SLOTS_V    = 9'(TIMER_SLOTS);
  localparam logic [8:0] SCAN_LAST  = 9'(SCAN_N - 1);

  // Interval span in nanoseconds: a 32-bit millisecond count times one million.
  localparam int SPAN_W = 52;
  localparam logic [SPAN_W-1:0] NS_PER_MS = SPAN_W'(1000000);

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Action codes on the input.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Status codes on the result.
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_INVALID = 1'b1;

  // Classified command kinds.
  typedef enum logic [1:0] {
    KIND_START,
    KIND_STOP,
    KIND_TICK,
    KIND_ERROR
  } kind_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        chan;
    logic              single;
    logic [SPAN_W-1:0] span;
    logic [63:0]       now;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic       valid;
    logic       status;
    logic       fired;
    logic [3:0] chan;
    logic       single;
    logic       last;
  } res_t;

endpackage

// File: rtl/core/mcst_front.sv
module mcst_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [3:0]         in_channel,
  input  logic [31:0]        in_delay_ms,
  input  logic               in_single,
  input  logic [63:0]        in_now_ns,
  input  logic               q_full,
  output logic               q_push,
  output mcst_pkg::cmd_t     q_data
);

  logic        f_vld_r;
  logic [1:0]  f_action_r;
  logic [3:0]  f_chan_r;
  logic [31:0] f_ms_r;
  logic        f_one_r;
  logic [63:0] f_now_r;
  logic        f_load;
  logic        chan_bad;
  mcst_pkg::kind_t kind;

  // The holding register drains into the queue whenever the queue has room.
  assign q_push = f_vld_r & ~q_full;
  assign busy   = f_vld_r & q_full;
  assign f_load = start & ~busy;

  // Capture the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_load | (f_vld_r & ~q_push);
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f_action_r <= in_action;
      f_chan_r   <= in_channel;
      f_ms_r     <= in_delay_ms;
      f_one_r    <= in_single;
      f_now_r    <= in_now_ns;
    end
  end

  // Classify the command and refuse bad arguments here, so the back end only executes.
  assign chan_bad = (9'(f_chan_r) >= mcst_pkg::SLOTS_V);

  always_comb begin
    case (f_action_r)
      mcst_pkg::ACT_START: begin
        kind = (f_ms_r == 32'd0 || chan_bad) ? mcst_pkg::KIND_ERROR : mcst_pkg::KIND_START;
      end
      mcst_pkg::ACT_STOP: begin
        kind = chan_bad ? mcst_pkg::KIND_ERROR : mcst_pkg::KIND_STOP;
      end
      mcst_pkg::ACT_TICK: begin
        kind = mcst_pkg::KIND_TICK;
      end
      default: begin
        kind = mcst_pkg::KIND_ERROR;
      end
    endcase
  end

  // The interval is scaled to nanoseconds on the way into the queue.
  always_comb begin
    q_data.kind   = kind;
    q_data.chan   = f_chan_r;
    q_data.single = f_one_r;
    q_data.span   = mcst_pkg::SPAN_W'(f_ms_r) * mcst_pkg::NS_PER_MS;
    q_data.now    = f_now_r;
  end

endmodule

// File: rtl/core/mcst_queue.sv
module mcst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mcst_pkg::cmd_t     push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output mcst_pkg::cmd_t     head
);

  mcst_pkg::cmd_t              mem_r [mcst_pkg::QDEPTH];
  logic [mcst_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [mcst_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [mcst_pkg::QPTR_W:0]   count_r;

  assign full      = (count_r == (mcst_pkg::QPTR_W+1)'(mcst_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == mcst_pkg::QPTR_W'(mcst_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == mcst_pkg::QPTR_W'(mcst_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/mcst_back.sv
module mcst_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  mcst_pkg::cmd_t     q_head,
  output logic               q_pop,
  output mcst_pkg::res_t     res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                         state_r;
  logic [mcst_pkg::SLOT_W-1:0]    idx_r;
  logic [63:0]                    now_r;
  logic                           pend_vld_r;
  logic [3:0]                     pend_chan_r;
  logic                           pend_one_r;
  mcst_pkg::res_t                 res_r;
  logic [mcst_pkg::TIMER_SLOTS-1:0] armed_r;
  logic [mcst_pkg::TIMER_SLOTS-1:0] single_r;
  logic [mcst_pkg::SPAN_W-1:0]    span_r [mcst_pkg::TIMER_SLOTS];
  logic [63:0]                    deadline_r [mcst_pkg::TIMER_SLOTS];

  logic                           hit;
  logic                           scan_end;
  logic [mcst_pkg::SLOT_W-1:0]    head_idx;
  logic                           start_we;
  logic                           dl_we;
  logic [mcst_pkg::SLOT_W-1:0]    dl_idx;
  logic [63:0]                    dl_val;

  // Deadline from a base time and a span, held at all ones on overflow.
  function automatic logic [63:0] sat_add(input logic [63:0] base,
                                          input logic [mcst_pkg::SPAN_W-1:0] span);
    logic [64:0] sum;
    sum = {1'b0, base} + 65'(span);
    return sum[64] ? {64{1'b1}} : sum[63:0];
  endfunction

  // A valid result beat with the given fields.
  function automatic mcst_pkg::res_t make_res(input logic status, input logic fired,
                                              input logic [3:0] chan, input logic single,
                                              input logic last);
    mcst_pkg::res_t r;
    r.valid  = 1'b1;
    r.status = status;
    r.fired  = fired;
    r.chan   = chan;
    r.single = single;
    r.last   = last;
    return r;
  endfunction

  assign q_pop    = (state_r == ST_IDLE) & q_vld;
  assign head_idx = mcst_pkg::SLOT_W'(q_head.chan);
  assign hit      = armed_r[idx_r] && (now_r >= deadline_r[idx_r]);
  assign scan_end = (9'(idx_r) == mcst_pkg::SCAN_LAST);
  assign start_we = q_pop && (q_head.kind == mcst_pkg::KIND_START);
  assign res      = res_r;

  // One deadline write a cycle: either a start or a periodic rearm during the scan.
  always_comb begin
    dl_we  = 1'b0;
    dl_idx = idx_r;
    dl_val = sat_add(now_r, span_r[idx_r]);
    if (start_we) begin
      dl_we  = 1'b1;
      dl_idx = head_idx;
      dl_val = sat_add(q_head.now, q_head.span);
    end else if (state_r == ST_SCAN && hit && !single_r[idx_r]) begin
      dl_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_r[dl_idx] <= dl_val;
    end
    if (start_we) begin
      span_r[head_idx] <= q_head.span;
    end
  end

  // Sequencer: executes one command, scanning channels in order for a tick.
  // A fired channel is held back one step so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
      armed_r    <= '0;
      single_r   <= '0;
      res_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_vld) begin
            case (q_head.kind)
              mcst_pkg::KIND_START: begin
                armed_r[head_idx]  <= 1'b1;
                single_r[head_idx] <= q_head.single;
                res_r <= make_res(mcst_pkg::STAT_OK, 1'b0, 4'd0, 1'b0, 1'b1);
              end
              mcst_pkg::KIND_STOP: begin
                armed_r[head_idx] <= 1'b0;
                res_r <= make_res(mcst_pkg::STAT_OK, 1'b0, 4'd0, 1'b0, 1'b1);
              end
              mcst_pkg::KIND_TICK: begin
                now_r      <= q_head.now;
                idx_r      <= '0;
                pend_vld_r <= 1'b0;
                state_r    <= ST_SCAN;
                res_r      <= '0;
              end
              default: begin
                res_r <= make_res(mcst_pkg::STAT_INVALID, 1'b0, 4'd0, 1'b0, 1'b1);
              end
            endcase
          end else begin
            res_r <= '0;
          end
        end
        ST_SCAN: begin
          if (hit && pend_vld_r) begin
            res_r <= make_res(mcst_pkg::STAT_OK, 1'b1, pend_chan_r, pend_one_r, 1'b0);
          end else begin
            res_r <= '0;
          end
          if (hit) begin
            pend_vld_r  <= 1'b1;
            pend_chan_r <= 4'(idx_r);
            pend_one_r  <= single_r[idx_r];
            if (single_r[idx_r]) begin
              armed_r[idx_r] <= 1'b0;
            end
          end
          if (scan_end) begin
            state_r <= ST_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (pend_vld_r) begin
            res_r <= make_res(mcst_pkg::STAT_OK, 1'b1, pend_chan_r, pend_one_r, 1'b1);
          end else begin
            res_r <= make_res(mcst_pkg::STAT_OK, 1'b0, 4'd0, 1'b0, 1'b1);
          end
          pend_vld_r <= 1'b0;
          state_r    <= ST_IDLE;
        end
        default: begin
          res_r   <= '0;
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/multi_channel_software_timer.sv
// Start and stop beats give their single result once they pass the input register, the command
// queue and the result register; a refused beat too. A tick occupies the execution unit for
// one compare per channel and then a final state that flushes the last result. A two-entry
// command queue lets new beats be taken during a tick scan.
// Results are strobed for one cycle on out_valid and cannot be held off by the receiver.
// Synchronous active-low reset disarms every channel; stored spans and deadlines are kept.
module multi_channel_software_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_channel,
  input  logic [31:0] in_delay_ms,
  input  logic        in_single,
  input  logic [63:0] in_now_ns,
  output logic        out_valid,
  output logic        out_status,
  output logic        out_fired,
  output logic [3:0]  out_fired_channel,
  output logic        out_fired_single,
  output logic        out_last
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_vld;
  mcst_pkg::cmd_t q_data;
  mcst_pkg::cmd_t q_head;
  mcst_pkg::res_t res;

  // Front end: takes the beat, classifies it and scales the interval.
  mcst_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_action   (in_action),
    .in_channel  (in_channel),
    .in_delay_ms (in_delay_ms),
    .in_single   (in_single),
    .in_now_ns   (in_now_ns),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  // Command queue between the two halves.
  mcst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_vld),
    .head      (q_head)
  );

  // Back end: channel state and the tick scan.
  mcst_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_head (q_head),
    .q_pop  (q_pop),
    .res    (res)
  );

  assign out_valid         = res.valid;
  assign out_status        = res.status;
  assign out_fired         = res.fired;
  assign out_fired_channel = res.chan;
  assign out_fired_single  = res.single;
  assign out_last          = res.last;

endmodule

// File: sim/multi_channel_software_timer_test.sv
module multi_channel_software_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code that the block does not know, answered with an error.
  localparam logic [1:0]  ACT_UNKNOWN     = 2'd3;
  localparam logic [63:0] NANOS_PER_MILLI = 64'd1_000_000;
  localparam logic [63:0] TIME_MAX        = '1;
  localparam int          TOTAL_BEATS     = 350;
  localparam int          STALL_LIMIT     = 4000;
  localparam int          DRAIN_CYCLES    = mcst_pkg::TIMER_SLOTS + 8;

  // One command beat, with the idle cycles to leave before it is offered.
  typedef struct {
    logic [1:0]  action;
    logic [3:0]  channel;
    logic [31:0] delay_ms;
    logic        single;
    logic [63:0] now_ns;
    int          gap;
  } cmd_beat_t;

  // One expected result beat.
  typedef struct {
    logic       status;
    logic       fired;
    logic [3:0] chan;
    logic       single;
    logic       last;
  } result_beat_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  in_action      = '0;
  logic [3:0]  in_channel     = '0;
  logic [31:0] in_delay_ms    = '0;
  logic        in_single      = 1'b0;
  logic [63:0] in_now_ns      = '0;
  logic        out_valid;
  logic        out_status;
  logic        out_fired;
  logic [3:0]  out_fired_channel;
  logic        out_fired_single;
  logic        out_last;

  // Predicted state of every timer channel.
  logic        ch_armed    [mcst_pkg::TIMER_SLOTS];
  logic        ch_single   [mcst_pkg::TIMER_SLOTS];
  logic [31:0] ch_period   [mcst_pkg::TIMER_SLOTS];
  logic [63:0] ch_deadline [mcst_pkg::TIMER_SLOTS];

  cmd_beat_t    cmd_queue[$];
  result_beat_t due_results[$];

  logic [63:0] wall = '0;
  logic        quiet = 1'b0;
  int          hold_off = 0;
  int          stall_cycles = 0;
  int          mismatches = 0;
  int          beats_taken = 0;
  int          results_seen = 0;
  int          expiries_seen = 0;
  int          widest_tick = 0;

  multi_channel_software_timer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_channel        (in_channel),
    .in_delay_ms       (in_delay_ms),
    .in_single         (in_single),
    .in_now_ns         (in_now_ns),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_fired         (out_fired),
    .out_fired_channel (out_fired_channel),
    .out_fired_single  (out_fired_single),
    .out_last          (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Deadline a given number of milliseconds after now, held at the top of the range.
  function automatic logic [63:0] deadline_after(logic [63:0] now, logic [31:0] ms);
    logic [64:0] sum;
    sum = {1'b0, now} + {1'b0, 64'(ms) * NANOS_PER_MILLI};
    return sum[64] ? TIME_MAX : sum[63:0];
  endfunction

  function automatic void post_result(logic status, logic fired, logic [3:0] chan,
                                      logic single, logic last);
    result_beat_t r;
    r.status = status;
    r.fired  = fired;
    r.chan   = chan;
    r.single = single;
    r.last   = last;
    due_results.push_back(r);
  endfunction

  // Updates the channel state for one accepted beat and queues the results it causes.
  function automatic void timer_predict(cmd_beat_t c);
    int fires;
    fires = 0;
    case (c.action)
      mcst_pkg::ACT_START: begin
        if (c.delay_ms == 32'd0 || int'(c.channel) >= mcst_pkg::TIMER_SLOTS) begin
          post_result(mcst_pkg::STAT_INVALID, 1'b0, 4'd0, 1'b0, 1'b1);
        end else begin
          ch_armed[c.channel]    = 1'b1;
          ch_single[c.channel]   = c.single;
          ch_period[c.channel]   = c.delay_ms;
          ch_deadline[c.channel] = deadline_after(c.now_ns, c.delay_ms);
          post_result(mcst_pkg::STAT_OK, 1'b0, 4'd0, 1'b0, 1'b1);
        end
      end
      mcst_pkg::ACT_STOP: begin
        if (int'(c.channel) >= mcst_pkg::TIMER_SLOTS) begin
          post_result(mcst_pkg::STAT_INVALID, 1'b0, 4'd0, 1'b0, 1'b1);
        end else begin
          ch_armed[c.channel] = 1'b0;
          post_result(mcst_pkg::STAT_OK, 1'b0, 4'd0, 1'b0, 1'b1);
        end
      end
      mcst_pkg::ACT_TICK: begin
        // Channels are reported in ascending order; the final one carries last.
        for (int i = 0; i < mcst_pkg::TIMER_SLOTS && i < 16; i++) begin
          if (ch_armed[i] && c.now_ns >= ch_deadline[i]) begin
            post_result(mcst_pkg::STAT_OK, 1'b1, 4'(i), ch_single[i], 1'b0);
            fires++;
            if (ch_single[i]) begin
              ch_armed[i] = 1'b0;
            end else begin
              ch_deadline[i] = deadline_after(c.now_ns, ch_period[i]);
            end
          end
        end
        if (fires == 0) begin
          post_result(mcst_pkg::STAT_OK, 1'b0, 4'd0, 1'b0, 1'b1);
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
        expiries_seen += fires;
        if (fires > widest_tick) widest_tick = fires;
      end
      default: begin
        post_result(mcst_pkg::STAT_INVALID, 1'b0, 4'd0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Appends a command beat; idle gaps are left out during quiet stretches.
  function automatic void queue_cmd(logic [1:0] action, logic [3:0] channel,
                                    logic [31:0] delay_ms, logic single,
                                    logic [63:0] now_ns);
    cmd_beat_t c;
    c.action   = action;
    c.channel  = channel;
    c.delay_ms = delay_ms;
    c.single   = single;
    c.now_ns   = now_ns;
    c.gap      = quiet ? 0 : int'($urandom_range(0, 10));
    cmd_queue.push_back(c);
  endfunction

  // Driver: offers the head of the queue and retires it once the beat is taken.
  always @(posedge clk) begin : drive
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        timer_predict(cmd_queue[0]);
        void'(cmd_queue.pop_front());
        beats_taken++;
        if (cmd_queue.size() != 0) hold_off = cmd_queue[0].gap;
      end
      // A beat that is still waiting for the block is held as it is.
      if (!start || !busy) begin
        if (hold_off != 0) begin
          hold_off--;
          start <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          start       <= 1'b1;
          in_action   <= cmd_queue[0].action;
          in_channel  <= cmd_queue[0].channel;
          in_delay_ms <= cmd_queue[0].delay_ms;
          in_single   <= cmd_queue[0].single;
          in_now_ns   <= cmd_queue[0].now_ns;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk) begin : observe
    result_beat_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result beat arrived with no result expected");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_fired !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, out_fired);
          mismatches++;
        end
        if (out_fired_channel !== want.chan) begin
          $error("fired_channel: expected %0d, got %0d", want.chan, out_fired_channel);
          mismatches++;
        end
        if (out_fired_single !== want.single) begin
          $error("fired one-shot flag: expected %0d, got %0d", want.single,
                 out_fired_single);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("multi_channel_software_timer_test NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int sel;
    int pick;

    for (int i = 0; i < mcst_pkg::TIMER_SLOTS; i++) begin
      ch_armed[i]    = 1'b0;
      ch_single[i]   = 1'b0;
      ch_period[i]   = '0;
      ch_deadline[i] = '0;
    end

    // Directed part: boundaries of the deadline compare, one-shot against
    // periodic, refused and unknown commands, restarts and saturation.
    queue_cmd(mcst_pkg::ACT_START, 4'd0, 32'd1, 1'b1, 64'd0);
    queue_cmd(mcst_pkg::ACT_START, 4'd7, 32'd2, 1'b0, 64'd0);
    queue_cmd(mcst_pkg::ACT_START, 4'd3, 32'd0, 1'b1, 64'd0);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 64'd999_999);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 64'd1_000_000);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd15, '1, 1'b1, 64'd2_000_000);
    queue_cmd(mcst_pkg::ACT_START, 4'd7, 32'd3, 1'b1, 64'd2_500_000);
    queue_cmd(mcst_pkg::ACT_STOP, 4'd7, 32'd0, 1'b0, 64'd0);
    queue_cmd(mcst_pkg::ACT_STOP, 4'd7, '1, 1'b1, TIME_MAX);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 64'd5_500_000);
    queue_cmd(mcst_pkg::ACT_START, 4'd15, '1, 1'b0, {32'hFFFF_FFFF, 32'h0});
    queue_cmd(mcst_pkg::ACT_START, 4'd9, 32'd1, 1'b1, TIME_MAX);
    queue_cmd(mcst_pkg::ACT_START, 4'd10, 32'd5, 1'b0, TIME_MAX - 64'd1);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, TIME_MAX - 64'd1);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, TIME_MAX);
    queue_cmd(mcst_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, TIME_MAX);
    queue_cmd(ACT_UNKNOWN, '1, '1, 1'b1, TIME_MAX);
    queue_cmd(ACT_UNKNOWN, 4'd0, 32'd0, 1'b0, 64'd0);
    queue_cmd(mcst_pkg::ACT_STOP, 4'd10, 32'd0, 1'b0, 64'd0);
    queue_cmd(mcst_pkg::ACT_STOP, 4'd15, 32'd0, 1'b0, 64'd0);

    // Random part: mostly a coherent time line with short intervals, so that
    // channels really expire, plus jumps in time and stray commands.
    wall = 64'd10_000_000;
    pick = 1;
    while (cmd_queue.size() < TOTAL_BEATS) begin
      if ($urandom_range(0, 29) == 0) quiet = ~quiet;
      sel = $urandom_range(0, 99);
      if (pick != 0 || sel < 2) begin
        // Every channel armed at once, then expired by a single tick.
        pick = 0;
        for (int k = 0; k < 16; k++) begin
          queue_cmd(mcst_pkg::ACT_START, 4'(k), 32'd1, 1'($urandom_range(0, 1)), wall);
        end
        wall += NANOS_PER_MILLI;
        queue_cmd(mcst_pkg::ACT_TICK, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)), wall);
      end else if (sel < 5) begin
        if ($urandom_range(0, 1) == 0) wall = {$urandom, $urandom};
        else wall = {32'hFFFF_FFFF, $urandom};
      end else if (sel < 40) begin
        case ($urandom_range(0, 19))
          0:       queue_cmd(mcst_pkg::ACT_START, 4'($urandom_range(0, 15)), 32'd0,
                             1'($urandom_range(0, 1)), wall);
          1:       queue_cmd(mcst_pkg::ACT_START, 4'($urandom_range(0, 15)), $urandom,
                             1'($urandom_range(0, 1)), wall);
          default: queue_cmd(mcst_pkg::ACT_START, 4'($urandom_range(0, 15)),
                             32'($urandom_range(1, 6)), 1'($urandom_range(0, 1)), wall);
        endcase
      end else if (sel < 50) begin
        queue_cmd(mcst_pkg::ACT_STOP, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)), {$urandom, $urandom});
      end else if (sel < 95) begin
        wall += 64'($urandom_range(0, 2_500_000));
        queue_cmd(mcst_pkg::ACT_TICK, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)), wall);
      end else begin
        queue_cmd(ACT_UNKNOWN, 4'($urandom_range(0, 15)), $urandom,
                  1'($urandom_range(0, 1)), {$urandom, $urandom});
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be taken and every result to come back.
    while (cmd_queue.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command beats and checked %0d result beats.", beats_taken, results_seen);
    $display("Predicted %0d channel expiries, up to %0d from one tick.",
             expiries_seen, widest_tick);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("multi_channel_software_timer_test OK");
    end else begin
      $display("multi_channel_software_timer_test NOT OK");
    end
    $finish;
  end

endmodule
